>>> sv/vca_pkg.sv
package vca_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_REQUEST  = 2'd0,
        CMD_ALLOCATE = 2'd1,
        CMD_RELEASE  = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    // item held in the queue between front and back
    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] dst_port;
        logic [1:0] out_vc;
        logic [2:0] in_port;
        logic [1:0] in_vc;
    } t_item;

    // result fields
    typedef struct packed {
        logic       grant_valid;
        logic [2:0] grant_out_port;
        logic [1:0] grant_out_vc;
        logic [2:0] grant_in_port;
        logic [1:0] grant_in_vc;
        logic       request_present;
        logic [4:0] pending_count;
        logic       all_empty;
    } t_result;

endpackage

>>> sv/vca_queue.sv
// Short item queue that decouples input acceptance from execution.
module vca_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vca_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output vca_pkg::t_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    vca_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end
endmodule

>>> sv/vca_engine.sv
// Back end: executes one item at a time, one requester slot per search step.
module vca_engine #(
    parameter int PORTS = 5,
    parameter int VCS   = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  vca_pkg::t_item  i_item,
    output logic            o_item_pop,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output vca_pkg::t_result o_res,
    output logic            o_res_last
);
    localparam int NREQ = PORTS * VCS;
    localparam int NOV  = PORTS * VCS;
    localparam int RW   = (NREQ > 1) ? $clog2(NREQ) : 1;
    localparam int PW   = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int VW   = (VCS > 1) ? $clog2(VCS) : 1;
    localparam int CW   = $clog2(NREQ + 1);
    localparam int TW   = $clog2(NREQ + 1);
    localparam int MW   = $clog2(PORTS * NREQ);
    localparam int OW   = (NOV > 1) ? $clog2(NOV) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SRCH  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_FINAL = 5'b10000
    } t_state;

    t_state r_state;

    // request bits: flip-flops, cleared by reset
    logic [NREQ-1:0] r_req [PORTS];
    // wanted vc: memory, undefined until written
    logic [1:0]      r_want [PORTS*NREQ];
    logic [NOV-1:0]  r_free;
    logic [RW-1:0]   r_lw [NOV];
    logic [CW-1:0]   r_cnt [PORTS];

    vca_pkg::t_item r_it;
    logic [2:0]    r_p;
    logic [VW-1:0] r_v;
    logic [RW-1:0] r_j;
    logic [TW-1:0] r_t;
    logic          r_any;
    logic          r_rd_ok;
    logic [1:0]    r_rd;
    vca_pkg::t_result r_res;
    vca_pkg::t_result r_hold;
    logic          r_last;
    logic          r_valid;

    logic addr_ok, ovc_ok;
    logic cur_bit, do_req, do_rel, nb_after, empty_after;
    logic res_slot, res_load;
    logic [RW-1:0] idx;
    logic [PW-1:0] opi;
    logic [MW-1:0] wa, ra;
    logic [OW-1:0] ovi;
    logic [PORTS-1:0] nz, nz_after;
    logic all_empty;
    logic [PW-1:0] cur_p;
    logic [OW-1:0] cur_ov;
    logic last_ov;
    logic [RW-1:0] j_next;
    logic [VW-1:0] j_vc;
    logic [2:0]    j_port;
    logic [CW-1:0] cnt_after;

    assign addr_ok = (32'(r_it.dst_port) < PORTS) && (32'(r_it.in_port) < PORTS)
                  && (32'(r_it.in_vc) < VCS);
    assign ovc_ok  = 32'(r_it.out_vc) < VCS;
    assign opi     = PW'(r_it.dst_port);
    assign idx     = addr_ok ? RW'(32'(r_it.in_port) + PORTS * 32'(r_it.in_vc)) : '0;
    assign wa      = MW'(32'(opi) * NREQ + 32'(idx));
    assign ovi     = OW'(32'(opi) * VCS + 32'(r_it.out_vc));
    assign cur_p   = PW'(r_p);
    assign cur_ov  = OW'(32'(cur_p) * VCS + 32'(r_v));
    assign last_ov = (32'(r_p) == PORTS - 1) && (32'(r_v) == VCS - 1);
    assign j_next  = (32'(r_j) == NREQ - 1) ? '0 : r_j + 1'b1;
    assign ra      = MW'(32'(cur_p) * NREQ + 32'(j_next));

    // effect of a request or release on the addressed bit and count
    assign cur_bit  = addr_ok ? r_req[opi][idx] : 1'b0;
    assign do_req   = (r_it.cmd == vca_pkg::CMD_REQUEST) && addr_ok && ovc_ok && !cur_bit;
    assign do_rel   = (r_it.cmd == vca_pkg::CMD_RELEASE) && addr_ok;
    assign nb_after = do_req | (cur_bit & !do_rel);
    assign cnt_after = (32'(r_it.dst_port) < PORTS)
                     ? r_cnt[opi] + CW'(do_req) - CW'(do_rel && cur_bit) : '0;

    always_comb begin
        for (int p = 0; p < PORTS; p++) nz[p] = (r_cnt[p] != '0);
    end
    assign all_empty = ~|nz;

    always_comb begin
        nz_after = nz;
        if (addr_ok) nz_after[opi] = (cnt_after != '0);
    end
    assign empty_after = ~|nz_after;

    // split slot index into input vc and input port by compare
    always_comb begin
        j_vc = '0;
        for (int k = 1; k < VCS; k++)
            if (32'(j_next) >= k * PORTS) j_vc = VW'(k);
    end
    assign j_port = 3'(32'(j_next) - PORTS * 32'(j_vc));

    assign o_item_pop  = (r_state == S_IDLE) && i_item_valid && !r_valid;
    assign o_res_valid = r_valid;
    assign o_res       = r_res;
    assign o_res_last  = r_last;

    // result register may load when empty or being drained
    assign res_slot = !r_valid || i_res_ready;
    assign res_load = res_slot && ((r_state == S_EMIT && r_any) || r_state == S_FINAL);

    // wanted vc memory, registered read of the slot after r_j
    always_ff @(posedge i_clk) begin
        if (r_state == S_FINAL && res_slot && do_req)
            r_want[wa] <= r_it.out_vc;
        r_rd <= r_want[ra];
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_load) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '1;
            r_any   <= 1'b0;
            for (int p = 0; p < PORTS; p++) begin
                r_req[p] <= '0;
                r_cnt[p] <= '0;
            end
            for (int k = 0; k < NOV; k++) r_lw[k] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_item_pop) begin
                        r_it    <= i_item;
                        r_p     <= '0;
                        r_v     <= '0;
                        r_any   <= 1'b0;
                        r_state <= (i_item.cmd == vca_pkg::CMD_ALLOCATE && !all_empty)
                                   ? S_SCAN : S_FINAL;
                    end
                end
                // pick next output vc; start its search
                S_SCAN: begin
                    if (r_free[cur_ov]) begin
                        r_j     <= r_lw[cur_ov];
                        r_t     <= '0;
                        r_rd_ok <= 1'b0;
                        r_state <= S_SRCH;
                    end else if (last_ov) begin
                        r_state <= S_FINAL;
                    end else if (32'(r_v) == VCS - 1) begin
                        r_v <= '0;
                        r_p <= r_p + 3'd1;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                // r_rd holds wanted vc of slot j_next once r_rd_ok
                S_SRCH: begin
                    if (!r_rd_ok) begin
                        r_rd_ok <= 1'b1;
                    end else if (r_req[cur_p][j_next] && r_rd == 2'(r_v)) begin
                        r_free[cur_ov] <= 1'b0;
                        r_lw[cur_ov]   <= j_next;
                        r_state <= S_EMIT;
                    end else if (32'(r_t) == NREQ - 1) begin
                        r_state <= last_ov ? S_FINAL : S_SCAN;
                        if (!last_ov) begin
                            if (32'(r_v) == VCS - 1) begin
                                r_v <= '0;
                                r_p <= r_p + 3'd1;
                            end else r_v <= r_v + 1'b1;
                        end
                    end else begin
                        r_j     <= j_next;
                        r_t     <= r_t + 1'b1;
                        r_rd_ok <= 1'b0;
                    end
                end
                // new grant is held until a later grant or the end proves last;
                // a grant already held goes out first
                S_EMIT: begin
                    if (!r_any || res_slot) begin
                        if (r_any) begin
                            r_res  <= r_hold;
                            r_last <= 1'b0;
                        end
                        r_any <= 1'b1;
                        r_hold.grant_valid    <= 1'b1;
                        r_hold.grant_out_port <= r_p;
                        r_hold.grant_out_vc   <= 2'(r_v);
                        r_hold.grant_in_port  <= j_port;
                        r_hold.grant_in_vc    <= 2'(j_vc);
                        // status fields are constant during a round
                        r_hold.request_present <= nb_after;
                        r_hold.pending_count   <= 5'(cnt_after);
                        r_hold.all_empty       <= empty_after;
                        if (last_ov) r_state <= S_FINAL;
                        else begin
                            r_state <= S_SCAN;
                            if (32'(r_v) == VCS - 1) begin
                                r_v <= '0;
                                r_p <= r_p + 3'd1;
                            end else r_v <= r_v + 1'b1;
                        end
                    end
                end
                // apply request/release, emit the final result
                S_FINAL: begin
                    if (res_slot) begin
                        if (do_req) begin
                            r_req[opi][idx] <= 1'b1;
                            r_cnt[opi] <= r_cnt[opi] + 1'b1;
                        end
                        if (do_rel) begin
                            r_req[opi][idx] <= 1'b0;
                            if (cur_bit) r_cnt[opi] <= r_cnt[opi] - 1'b1;
                            if (ovc_ok) r_free[ovi] <= 1'b1;
                        end
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_any) begin
                            // held grant is the last result of the round
                            r_res <= r_hold;
                            r_any <= 1'b0;
                        end else begin
                            r_res.grant_valid     <= 1'b0;
                            r_res.grant_out_port  <= '0;
                            r_res.grant_out_vc    <= '0;
                            r_res.grant_in_port   <= '0;
                            r_res.grant_in_vc     <= '0;
                            r_res.request_present <= nb_after;
                            r_res.pending_count   <= 5'(cnt_after);
                            r_res.all_empty       <= empty_after;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/virtual_channel_allocator.sv
// Channel   Dir  Handshake              Payload
// s_axis    in   i_s_axis_tvalid/tready cmd, dst_port, out_vc, in_port, in_vc
// m_axis    out  o_m_axis_tvalid/tready grant and status fields, tlast
// Request and release: pass through the queue, execute and result register.
// Allocate: each output VC gets a scan step; a free one then searches the requester
// slots (registered read of the wanted-VC memory), plus an emit step per grant.
// The back end takes the next item only once its result register has drained.
// Reset: synchronous active low; requests clear, all output VCs free.
// Input is taken into a 2-deep queue while the back end works or stalls.
module virtual_channel_allocator #(
    parameter int PORTS = 5,
    parameter int VCS   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] cmd, [4:2] dst_port, [6:5] out_vc, [9:7] in_port, [11:10] in_vc
    input  logic [15:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] grant_valid, [3:1] grant_out_port, [5:4] grant_out_vc,
    // [8:6] grant_in_port, [10:9] grant_in_vc, [11] request_present,
    // [16:12] pending_count, [17] all_empty
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);
    vca_pkg::t_item   w_in, w_q;
    vca_pkg::t_result w_res;
    logic w_full, w_empty, w_pop;

    assign w_in.cmd      = vca_pkg::t_cmd'(i_s_axis_tdata[1:0]);
    assign w_in.dst_port = i_s_axis_tdata[4:2];
    assign w_in.out_vc   = i_s_axis_tdata[6:5];
    assign w_in.in_port  = i_s_axis_tdata[9:7];
    assign w_in.in_vc    = i_s_axis_tdata[11:10];
    assign o_s_axis_tready = !w_full;

    vca_queue #(.DEPTH(2)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(i_s_axis_tvalid && !w_full), .i_item(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_item(w_q)
    );

    vca_engine #(.PORTS(PORTS), .VCS(VCS)) u_engine (
        .i_clk, .i_rst_n,
        .i_item_valid(!w_empty), .i_item(w_q), .o_item_pop(w_pop),
        .o_res_valid(o_m_axis_tvalid), .i_res_ready(i_m_axis_tready),
        .o_res(w_res), .o_res_last(o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'd0, w_res.all_empty, w_res.pending_count,
        w_res.request_present, w_res.grant_in_vc, w_res.grant_in_port,
        w_res.grant_out_vc, w_res.grant_out_port, w_res.grant_valid};

    a_no_grant_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[10:1] == '0)
        else $error("idle result carries grant fields");
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[17] |-> o_m_axis_tdata[16:11] == '0)
        else $error("empty flag with pending requests");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed under stall");
endmodule
